// ===== rtl/core/uerm_pkg.sv =====
package uerm_pkg;

    // sequence length default
    localparam int READINGS_DEF = 5;

    // field and register widths
    localparam int TC_W   = 16;
    localparam int TRIG_W = 10;
    localparam int READ_W = 11;
    localparam int DIST_W = 12;
    localparam int REM_W  = 6;

    // ticks of echo width per centimeter
    localparam int CM_DIVISOR = 58;

    // configuration register reset values
    localparam logic [TC_W-1:0]   TIMEOUT_RST = 16'd30000;
    localparam logic [TRIG_W-1:0] TRIGGER_RST = 10'd150;

    // configuration register indexes
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_TRIGGER = 1'b1;

    // per-tick status flags from the ranging sequencer
    typedef struct packed {
        logic failed;
        logic done;
        logic busy;
        logic trigger;
    } t_tick_res;

    // reading store write request
    typedef struct packed {
        logic              en;
        logic [READ_W-1:0] data;
    } t_store_wr;

endpackage

// ===== rtl/core/uerm_tick.sv =====
module uerm_tick
    import uerm_pkg::*;
#(
    parameter int READINGS = READINGS_DEF,
    parameter int CNT_W    = $clog2(READINGS + 1),
    parameter int ADDR_W   = (READINGS > 1) ? $clog2(READINGS) : 1
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_step,
    input  logic              i_start,
    input  logic              i_echo,
    input  logic [TC_W-1:0]   i_timeout_us,
    input  logic [TRIG_W-1:0] i_trigger_us,
    output t_tick_res         o_res,
    output logic              o_enter_report,
    output t_store_wr         o_wr,
    output logic [ADDR_W-1:0] o_wr_addr,
    output logic [CNT_W-1:0]  o_valid_cnt
);

    typedef enum logic [4:0] {
        PH_IDLE   = 5'b00001,
        PH_TRIG   = 5'b00010,
        PH_WHIGH  = 5'b00100,
        PH_WLOW   = 5'b01000,
        PH_REPORT = 5'b10000
    } t_phase;

    t_phase             r_phase, n_phase;
    logic [TC_W-1:0]    r_tc, n_tc;
    logic [CNT_W-1:0]   r_attempt, n_attempt;
    logic [CNT_W-1:0]   r_valid_cnt, n_valid_cnt;
    logic [REM_W-1:0]   r_rem, n_rem;
    logic [READ_W-1:0]  r_cm, n_cm;
    logic [TC_W-1:0]    tc_inc;
    logic               finish;

    assign tc_inc      = r_tc + 16'd1;
    assign o_wr_addr   = r_valid_cnt[ADDR_W-1:0];
    assign o_valid_cnt = r_valid_cnt;

    // one tick of the ranging sequence
    always_comb begin
        n_phase     = r_phase;
        n_tc        = r_tc;
        n_attempt   = r_attempt;
        n_valid_cnt = r_valid_cnt;
        n_rem       = r_rem;
        n_cm        = r_cm;
        o_res       = '0;
        o_wr        = '0;
        finish      = 1'b0;
        case (r_phase)
            PH_TRIG: begin
                o_res.trigger = 1'b1;
                o_res.busy    = 1'b1;
                n_tc          = tc_inc;
                if (tc_inc >= {{(TC_W-TRIG_W){1'b0}}, i_trigger_us} || tc_inc == '0) begin
                    n_phase = PH_WHIGH;
                    n_tc    = '0;
                end
            end
            PH_WHIGH: begin
                o_res.busy = 1'b1;
                if (i_echo) begin
                    n_phase = PH_WLOW;
                    n_tc    = 16'd1;
                    n_rem   = REM_W'(1);
                    n_cm    = '0;
                end else begin
                    n_tc = tc_inc;
                    if (tc_inc >= i_timeout_us || tc_inc == '0) begin
                        finish = 1'b1;
                    end
                end
            end
            PH_WLOW: begin
                o_res.busy = 1'b1;
                if (!i_echo) begin
                    if (r_valid_cnt < CNT_W'(READINGS)) begin
                        o_wr.en     = i_step;
                        o_wr.data   = r_cm;
                        n_valid_cnt = r_valid_cnt + CNT_W'(1);
                    end
                    finish = 1'b1;
                end else if (r_tc >= i_timeout_us || r_tc == '1) begin
                    finish = 1'b1;
                end else begin
                    // width kept as quotient and remainder of the divisor
                    n_tc = tc_inc;
                    if (r_rem == REM_W'(CM_DIVISOR - 1)) begin
                        n_rem = '0;
                        n_cm  = r_cm + READ_W'(1);
                    end else begin
                        n_rem = r_rem + REM_W'(1);
                    end
                end
            end
            PH_REPORT: begin
                o_res.done   = 1'b1;
                o_res.failed = (r_valid_cnt == '0);
                n_phase      = PH_IDLE;
                n_tc         = '0;
            end
            default: begin
                n_phase = PH_IDLE;
                if (i_start) begin
                    n_phase     = PH_TRIG;
                    n_tc        = '0;
                    n_attempt   = '0;
                    n_valid_cnt = '0;
                end
            end
        endcase

        // end of one attempt
        if (finish) begin
            n_attempt = r_attempt + CNT_W'(1);
            n_tc      = '0;
            n_phase   = (n_attempt >= CNT_W'(READINGS)) ? PH_REPORT : PH_TRIG;
        end
    end

    assign o_enter_report = i_step && (n_phase == PH_REPORT);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_tc        <= '0;
            r_attempt   <= '0;
            r_valid_cnt <= '0;
            r_rem       <= '0;
            r_cm        <= '0;
        end else if (i_step) begin
            r_phase     <= n_phase;
            r_tc        <= n_tc;
            r_attempt   <= n_attempt;
            r_valid_cnt <= n_valid_cnt;
            r_rem       <= n_rem;
            r_cm        <= n_cm;
        end
    end

endmodule

// ===== rtl/core/uerm_median.sv =====
module uerm_median
    import uerm_pkg::*;
#(
    parameter int READINGS = READINGS_DEF,
    parameter int CNT_W    = $clog2(READINGS + 1),
    parameter int ADDR_W   = (READINGS > 1) ? $clog2(READINGS) : 1
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_store_wr         i_wr,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  logic              i_start,
    input  logic [CNT_W-1:0]  i_count,
    output logic              o_done,
    output logic [DIST_W-1:0] o_median
);

    typedef enum logic [2:0] {
        M_IDLE = 3'b001,
        M_READ = 3'b010,
        M_CMP  = 3'b100
    } t_mstate;

    logic [READ_W-1:0] r_mem [READINGS];
    logic [READ_W-1:0] r_rd_a, r_rd_b;

    t_mstate           r_state;
    logic [ADDR_W-1:0] r_i, r_j;
    logic [CNT_W-1:0]  r_n, r_rank;
    logic [DIST_W-1:0] r_acc;
    logic              r_done;

    logic              less;
    logic [CNT_W-1:0]  rank_now, rank_lo, rank_hi, n_last;
    logic              last_i, last_j;
    logic [DIST_W-1:0] add_lo, add_hi;

    // reading store: one write port, two registered read ports
    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr_addr] <= i_wr.data;
        end
        r_rd_a <= r_mem[r_i];
        r_rd_b <= r_mem[r_j];
    end

    // rank of entry i: entries below it, ties broken by position
    assign less     = (r_rd_b < r_rd_a) || (r_rd_b == r_rd_a && r_j < r_i);
    assign rank_now = r_rank + CNT_W'(less);
    assign n_last   = r_n - CNT_W'(1);
    assign rank_lo  = n_last >> 1;
    assign rank_hi  = r_n >> 1;
    assign last_i   = ({{(CNT_W-ADDR_W){1'b0}}, r_i} == n_last);
    assign last_j   = ({{(CNT_W-ADDR_W){1'b0}}, r_j} == n_last);
    assign add_lo   = (rank_now == rank_lo) ? DIST_W'(r_rd_a) : '0;
    assign add_hi   = (rank_now == rank_hi) ? DIST_W'(r_rd_a) : '0;

    // rank-select sequencer, alternating a read state and a compare state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= M_IDLE;
            r_done  <= 1'b0;
            r_i     <= '0;
            r_j     <= '0;
            r_rank  <= '0;
            r_n     <= '0;
            r_acc   <= '0;
        end else begin
            r_done <= 1'b0;
            case (r_state)
                M_IDLE: begin
                    if (i_start) begin
                        r_acc  <= '0;
                        r_i    <= '0;
                        r_j    <= '0;
                        r_rank <= '0;
                        r_n    <= i_count;
                        if (i_count == '0) begin
                            r_done <= 1'b1;
                        end else begin
                            r_state <= M_READ;
                        end
                    end
                end
                M_READ: begin
                    r_state <= M_CMP;
                end
                M_CMP: begin
                    r_state <= M_READ;
                    if (last_j) begin
                        r_acc  <= r_acc + add_lo + add_hi;
                        r_rank <= '0;
                        r_j    <= '0;
                        if (last_i) begin
                            r_state <= M_IDLE;
                            r_done  <= 1'b1;
                        end else begin
                            r_i <= r_i + ADDR_W'(1);
                        end
                    end else begin
                        r_rank <= rank_now;
                        r_j    <= r_j + ADDR_W'(1);
                    end
                end
                default: begin
                    r_state <= M_IDLE;
                end
            endcase
        end
    end

    assign o_done   = r_done;
    assign o_median = r_acc;

endmodule

// ===== rtl/core/ultrasonic_echo_ranging_median_unit.sv =====
// Ultrasonic echo ranging with median filtering.
//
// Input stream: one item per microsecond tick, tdata = {echo, start_req}.
// Output stream: exactly one item per input item, giving trigger, busy,
// done, failed and distance in half-centimeter units as seen at tick start.
// A start in idle runs READINGS trigger/echo attempts; after the last one
// a single report item carries the median of the valid readings.
//
// An ordinary tick passes through accept, step and output load.
// The tick that ends the last attempt also runs the rank-select median on
// a single comparator, ranking each of the n valid readings in turn.
// The output register is loaded after the step, or after the median on
// that one tick. The input is not ready while a tick is in work.
//
// Reset (synchronous, active low) returns the sequence to idle, restores
// timeout_us and trigger_us defaults and empties the output register.
// A stalled receiver holds the output item; the next input item is still
// accepted and processed, and waits for the output register to free.
module ultrasonic_echo_ranging_median_unit
    import uerm_pkg::*;
#(
    parameter int READINGS = READINGS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // configuration write port
    input  logic                 i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [TC_W-1:0]      i_cfg_wdata,
    // input stream
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [7:0]           s_axis_tdata,  // [0] start_req, [1] echo, rest zero
    // output stream
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [15:0]          m_axis_tdata   // [0] trigger, [1] busy_res, [2] done_res,
                                                // [3] failed, [15:4] distance_half_cm
);

    localparam int CNT_W  = $clog2(READINGS + 1);
    localparam int ADDR_W = (READINGS > 1) ? $clog2(READINGS) : 1;

    typedef enum logic [4:0] {
        T_IDLE   = 5'b00001,
        T_STEP   = 5'b00010,
        T_MSTART = 5'b00100,
        T_MWAIT  = 5'b01000,
        T_PUSH   = 5'b10000
    } t_tstate;

    t_tstate            r_state, n_state;
    logic [TC_W-1:0]    r_timeout;
    logic [TRIG_W-1:0]  r_trigger;
    logic               r_start, r_echo;
    t_tick_res          r_res;
    logic [DIST_W-1:0]  r_dist;
    logic               r_out_valid;
    logic [15:0]        r_out_data;

    t_tick_res          tick_res;
    logic               enter_report;
    t_store_wr          store_wr;
    logic [ADDR_W-1:0]  store_addr;
    logic [CNT_W-1:0]   valid_cnt;
    logic               med_done;
    logic [DIST_W-1:0]  median;
    logic               in_accept, out_free;

    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign out_free      = !r_out_valid || m_axis_tready;
    assign s_axis_tready = (r_state == T_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout <= TIMEOUT_RST;
            r_trigger <= TRIGGER_RST;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                CFG_TIMEOUT: r_timeout <= i_cfg_wdata;
                CFG_TRIGGER: r_trigger <= i_cfg_wdata[TRIG_W-1:0];
                default: ;
            endcase
        end
    end

    uerm_tick #(
        .READINGS (READINGS),
        .CNT_W    (CNT_W),
        .ADDR_W   (ADDR_W)
    ) u_tick (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_step         (r_state == T_STEP),
        .i_start        (r_start),
        .i_echo         (r_echo),
        .i_timeout_us   (r_timeout),
        .i_trigger_us   (r_trigger),
        .o_res          (tick_res),
        .o_enter_report (enter_report),
        .o_wr           (store_wr),
        .o_wr_addr      (store_addr),
        .o_valid_cnt    (valid_cnt)
    );

    uerm_median #(
        .READINGS (READINGS),
        .CNT_W    (CNT_W),
        .ADDR_W   (ADDR_W)
    ) u_median (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr      (store_wr),
        .i_wr_addr (store_addr),
        .i_start   (r_state == T_MSTART),
        .i_count   (valid_cnt),
        .o_done    (med_done),
        .o_median  (median)
    );

    // tick sequencer
    always_comb begin
        n_state = r_state;
        case (r_state)
            T_IDLE:   if (in_accept) n_state = T_STEP;
            T_STEP:   n_state = enter_report ? T_MSTART : T_PUSH;
            T_MSTART: n_state = T_MWAIT;
            T_MWAIT:  if (med_done) n_state = T_PUSH;
            T_PUSH:   if (out_free) n_state = T_IDLE;
            default:  n_state = T_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= T_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // captured input item and tick result
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_start <= s_axis_tdata[0];
            r_echo  <= s_axis_tdata[1];
        end
        if (r_state == T_STEP) begin
            r_res  <= tick_res;
            r_dist <= (tick_res.done && !tick_res.failed) ? median : '0;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == T_PUSH && out_free) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == T_PUSH && out_free) begin
            r_out_data <= {r_dist, r_res.failed, r_res.done, r_res.busy, r_res.trigger};
        end
    end

endmodule

// ===== rtl/core/uerm_checker.sv =====
module uerm_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [15:0] m_axis_tdata
);

    // a stalled output item holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output item changed while stalled");

    // one tick at a time: input closes right after an accept
    a_one_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input accepted while previous tick in work");

    // report item never drives trigger or busy
    a_report_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[2] |-> !m_axis_tdata[0] && !m_axis_tdata[1])
        else $error("report item with trigger or busy set");

    // failure and distance only on the report item, and never together
    a_dist_report: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tdata[3] || m_axis_tdata[15:4] != 12'd0)
        |-> m_axis_tdata[2] && !(m_axis_tdata[3] && m_axis_tdata[15:4] != 12'd0))
        else $error("distance or failure outside a clean report item");

endmodule

bind ultrasonic_echo_ranging_median_unit uerm_checker u_uerm_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
